>>> rtl/circular_linked_queue_manager_macros.svh
// Assertion macros for the circular linked queue manager.
`ifndef CIRCULAR_LINKED_QUEUE_MANAGER_MACROS_SVH
`define CIRCULAR_LINKED_QUEUE_MANAGER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLQ_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Check that a condition in one cycle brings another in the next cycle.
`define CLQ_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

>>> rtl/clq_pkg.sv
// Package with types, codes and control structs of the queue manager.
`timescale 1ns / 1ps
package clq_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int KIND_W = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_QUEUED = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_NOT_MEMBER = 2'd3;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_APP_SELF = 2'd1;
  localparam kind_t KIND_APP_LINK = 2'd2;
  localparam kind_t KIND_REMOVE = 2'd3;

  typedef struct packed {
    logic accept;
    logic decode;
    logic rd;
    logic wr_a;
    logic wr_b;
    logic wr_rm;
    logic commit;
    logic load_out;
  } clq_cmd_t;

  typedef struct packed {
    kind_t kind;
    kind_t kind_q;
    logic  out_free;
  } clq_sts_t;

endpackage

>>> rtl/clq_req_if.sv
// Request channel interface: valid, ready and the request word.
`timescale 1ns / 1ps
interface clq_req_if;
  logic          valid;
  logic          ready;
  clq_pkg::op_t  op;
  clq_pkg::idx_t entry;

  modport source(output valid, op, entry, input ready);
  modport sink(input valid, op, entry, output ready);
endinterface

>>> rtl/clq_rsp_if.sv
// Response channel interface: valid, ready and the result word.
`timescale 1ns / 1ps
interface clq_rsp_if;
  logic             valid;
  logic             ready;
  clq_pkg::status_t status;
  clq_pkg::idx_t    removed_entry;
  clq_pkg::cnt_t    count;
  clq_pkg::idx_t    head;
  logic             head_valid;

  modport source(output valid, status, removed_entry, count, head, head_valid, input ready);
  modport sink(input valid, status, removed_entry, count, head, head_valid, output ready);
endinterface

>>> rtl/clq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module clq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/clq_ctrl.sv
// Controller state machine sequencing decode, link writes and result load.
`timescale 1ns / 1ps
module clq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  clq_pkg::clq_sts_t sts,
  output clq_pkg::clq_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WRA    = 3'd2;
  localparam logic [2:0] S_WRB    = 3'd3;
  localparam logic [2:0] S_RMW    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        cmd.rd = 1'b1;
        case (sts.kind) inside
          clq_pkg::KIND_APP_SELF, clq_pkg::KIND_APP_LINK: state_next = S_WRA;
          clq_pkg::KIND_REMOVE: state_next = S_RMW;
          default: state_next = S_DONE;
        endcase
      end
      S_WRA: begin
        cmd.wr_a = 1'b1;
        cmd.commit = 1'b1;
        state_next = (sts.kind_q == clq_pkg::KIND_APP_LINK) ? S_WRB : S_DONE;
      end
      S_WRB: begin
        cmd.wr_b = 1'b1;
        state_next = S_DONE;
      end
      S_RMW: begin
        cmd.wr_rm = 1'b1;
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/clq_dp.sv
// Datapath: link RAMs, membership bits, head and count, result register.
`timescale 1ns / 1ps
`include "circular_linked_queue_manager_macros.svh"
module clq_dp (
  input  logic              clk,
  input  logic              rst,
  input  clq_pkg::clq_cmd_t cmd,
  output clq_pkg::clq_sts_t sts,
  input  clq_pkg::op_t      req_op,
  input  clq_pkg::idx_t     req_entry,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output clq_pkg::status_t  rsp_status,
  output clq_pkg::idx_t     rsp_removed_entry,
  output clq_pkg::cnt_t     rsp_count,
  output clq_pkg::idx_t     rsp_head,
  output logic              rsp_head_valid
);

  clq_pkg::op_t     op_q;
  clq_pkg::idx_t    entry_q;
  clq_pkg::status_t status_q;
  clq_pkg::idx_t    removed_q;
  clq_pkg::kind_t   kind_q;
  clq_pkg::idx_t    tail_q;

  logic [clq_pkg::NUM_ENTRIES-1:0] member;
  clq_pkg::cnt_t count;
  clq_pkg::idx_t head;

  clq_pkg::status_t dec_status;
  clq_pkg::kind_t   dec_kind;
  logic             in_range;
  logic             is_member;
  logic             empty;

  logic          next_we;
  clq_pkg::idx_t next_waddr;
  clq_pkg::idx_t next_wdata;
  clq_pkg::idx_t next_rdata;
  logic          prev_we;
  clq_pkg::idx_t prev_waddr;
  clq_pkg::idx_t prev_wdata;
  clq_pkg::idx_t prev_raddr;
  clq_pkg::idx_t prev_rdata;

  assign in_range = clq_pkg::CNT_W'(entry_q) < clq_pkg::CNT_W'(clq_pkg::NUM_ENTRIES);
  assign is_member = in_range && member[entry_q];
  assign empty = (count == '0);

  always_comb begin
    dec_status = clq_pkg::ST_OK;
    dec_kind = clq_pkg::KIND_NONE;
    case (op_q)
      clq_pkg::OP_APPEND: begin
        if (!in_range) begin
          dec_status = clq_pkg::ST_NOT_MEMBER;
        end else if (is_member) begin
          dec_status = clq_pkg::ST_QUEUED;
        end else if (empty) begin
          dec_kind = clq_pkg::KIND_APP_SELF;
        end else begin
          dec_kind = clq_pkg::KIND_APP_LINK;
        end
      end
      clq_pkg::OP_REMOVE: begin
        if (empty) begin
          dec_status = clq_pkg::ST_EMPTY;
        end else if (!is_member) begin
          dec_status = clq_pkg::ST_NOT_MEMBER;
        end else begin
          dec_kind = clq_pkg::KIND_REMOVE;
        end
      end
      default: dec_kind = clq_pkg::KIND_NONE;
    endcase
  end

  assign sts.kind = dec_kind;
  assign sts.kind_q = kind_q;
  assign sts.out_free = !rsp_valid || rsp_ready;

  assign prev_raddr = (op_q == clq_pkg::OP_APPEND) ? head : entry_q;

  always_comb begin
    next_we = cmd.wr_a || cmd.wr_b || cmd.wr_rm;
    prev_we = next_we;
    next_waddr = entry_q;
    next_wdata = entry_q;
    prev_waddr = entry_q;
    prev_wdata = entry_q;
    if (cmd.wr_a) begin
      if (kind_q == clq_pkg::KIND_APP_LINK) begin
        next_wdata = head;
        prev_wdata = prev_rdata;
      end
    end else if (cmd.wr_b) begin
      next_waddr = tail_q;
      prev_waddr = head;
    end else if (cmd.wr_rm) begin
      next_waddr = prev_rdata;
      next_wdata = next_rdata;
      prev_waddr = next_rdata;
      prev_wdata = prev_rdata;
    end
  end

  clq_ram #(
    .WIDTH(clq_pkg::IDX_W),
    .DEPTH(clq_pkg::NUM_ENTRIES)
  ) u_next_ram (
    .clk  (clk),
    .we   (next_we),
    .waddr(next_waddr),
    .wdata(next_wdata),
    .re   (cmd.rd),
    .raddr(entry_q),
    .rdata(next_rdata)
  );

  clq_ram #(
    .WIDTH(clq_pkg::IDX_W),
    .DEPTH(clq_pkg::NUM_ENTRIES)
  ) u_prev_ram (
    .clk  (clk),
    .we   (prev_we),
    .waddr(prev_waddr),
    .wdata(prev_wdata),
    .re   (cmd.rd),
    .raddr(prev_raddr),
    .rdata(prev_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= req_op;
      entry_q <= req_entry;
    end
    if (cmd.decode) begin
      status_q <= dec_status;
      removed_q <= (dec_kind == clq_pkg::KIND_REMOVE) ? entry_q : '0;
    end
    if (cmd.wr_a) begin
      tail_q <= prev_rdata;
    end
    if (cmd.load_out) begin
      rsp_status <= status_q;
      rsp_removed_entry <= removed_q;
      rsp_count <= count;
      rsp_head <= head;
      rsp_head_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member <= '0;
      count <= '0;
      head <= '0;
      kind_q <= clq_pkg::KIND_NONE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        kind_q <= dec_kind;
      end
      if (cmd.commit) begin
        if (kind_q == clq_pkg::KIND_REMOVE) begin
          member[entry_q] <= 1'b0;
          count <= count - clq_pkg::CNT_W'(1);
          if (count == clq_pkg::CNT_W'(1)) begin
            head <= '0;
          end else if (head == entry_q) begin
            head <= next_rdata;
          end
        end else begin
          member[entry_q] <= 1'b1;
          count <= count + clq_pkg::CNT_W'(1);
          if (kind_q == clq_pkg::KIND_APP_SELF) begin
            head <= entry_q;
          end
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `CLQ_ASSERT(a_count_matches_members, clk, rst, $countones(member) == int'(count))
  `CLQ_ASSERT(a_empty_head_zero, clk, rst, (count != '0) || (head == '0))
  `CLQ_ASSERT_NEXT(a_append_sets_member, clk, rst, cmd.commit && (kind_q != clq_pkg::KIND_REMOVE), member[entry_q])
  `CLQ_ASSERT_NEXT(a_remove_clears_member, clk, rst, cmd.commit && (kind_q == clq_pkg::KIND_REMOVE), !member[entry_q])

endmodule

>>> rtl/circular_linked_queue_manager.sv
// Request to result valid: DECODE, then WRA and WRB for append to a non-empty
// queue, WRA for append to an empty one, RMW for remove, none for rejected
// ops, then DONE. Next request is taken in the cycle after the result loads;
// each link RAM has a single write port, and append to a non-empty queue
// writes twice. Synchronous rst clears membership, count, head and result
// valid; link RAMs are not cleared and only links of queued entries are used.
`timescale 1ns / 1ps
module circular_linked_queue_manager (
  input  logic clk,
  input  logic rst,
  clq_req_if.sink   req,
  clq_rsp_if.source rsp
);

  clq_pkg::clq_cmd_t cmd;
  clq_pkg::clq_sts_t sts;

  clq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clq_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_op           (req.op),
    .req_entry        (req.entry),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_removed_entry(rsp.removed_entry),
    .rsp_count        (rsp.count),
    .rsp_head         (rsp.head),
    .rsp_head_valid   (rsp.head_valid)
  );

endmodule
